### design/iidl_pkg.sv
`timescale 1ns / 1ps

package iidl_pkg;

  // default sizing of the list
  localparam int unsigned IIDL_DEPTH_DEF      = 16;
  localparam int unsigned IIDL_DATA_WIDTH_DEF = 8;

  // fixed field widths of the request and response
  localparam int unsigned POS_W     = 4;
  localparam int unsigned VALUE_W   = 8;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned COUNT_W   = 5;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    CTL_EMPTY = 1'b0,
    CTL_HOLD  = 1'b1
  } ctl_state_e;

  // controller to datapath command
  typedef struct packed {
    logic exec;
  } ctl_cmd_t;

endpackage

### design/iidl_req_if.sv
`timescale 1ns / 1ps

interface iidl_req_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [iidl_pkg::POS_W-1:0]    position;
  logic [iidl_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output cmd, output position, output value, input ready);
  modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

### design/iidl_rsp_if.sv
`timescale 1ns / 1ps

interface iidl_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [iidl_pkg::VALUE_W-1:0]   removed_value;
  logic [iidl_pkg::STATUS_W-1:0]  status;
  logic [iidl_pkg::COUNT_W-1:0]   count;

  modport source (output valid, output removed_value, output status, output count, input ready);
  modport sink   (input valid, input removed_value, input status, input count, output ready);
endinterface

### design/iidl_ctrl.sv
`timescale 1ns / 1ps

module iidl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output iidl_pkg::ctl_cmd_t cmd_o
);

  iidl_pkg::ctl_state_e state_q, state_d;
  logic accept;

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      iidl_pkg::CTL_EMPTY: begin
        if (accept) state_d = iidl_pkg::CTL_HOLD;
      end
      iidl_pkg::CTL_HOLD: begin
        if (accept) state_d = iidl_pkg::CTL_HOLD;
        else if (out_ready_i) state_d = iidl_pkg::CTL_EMPTY;
      end
      default: state_d = iidl_pkg::CTL_EMPTY;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      iidl_pkg::CTL_EMPTY: begin
        in_ready_o  = 1'b1;
      end
      iidl_pkg::CTL_HOLD: begin
        in_ready_o  = out_ready_i;
        out_valid_o = 1'b1;
      end
      default: begin
        in_ready_o  = 1'b0;
        out_valid_o = 1'b0;
      end
    endcase
    cmd_o.exec = in_valid_i && in_ready_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iidl_pkg::CTL_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### design/iidl_datapath.sv
`timescale 1ns / 1ps

module iidl_datapath #(
  parameter int unsigned DEPTH      = iidl_pkg::IIDL_DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = iidl_pkg::IIDL_DATA_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  iidl_pkg::ctl_cmd_t            cmd_i,
  input  logic                          op_i,
  input  logic [iidl_pkg::POS_W-1:0]    position_i,
  input  logic [iidl_pkg::VALUE_W-1:0]  value_i,
  output logic [iidl_pkg::VALUE_W-1:0]  removed_value_o,
  output logic [iidl_pkg::STATUS_W-1:0] status_o,
  output logic [iidl_pkg::COUNT_W-1:0]  count_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > iidl_pkg::POS_W) ? CNT_W : iidl_pkg::POS_W;
  // only the first entries can be addressed by a position
  localparam int unsigned RD_N  = (DEPTH < (1 << iidl_pkg::POS_W)) ? DEPTH
                                                                   : (1 << iidl_pkg::POS_W);

  logic [DATA_WIDTH-1:0] entries_q [DEPTH];
  logic [DATA_WIDTH-1:0] entries_d [DEPTH];
  logic [CNT_W-1:0]      count_q, count_d;

  logic [CMP_W-1:0]      pos_ext, cnt_ext;
  logic                  is_insert;
  logic                  ins_ok, del_ok;
  logic                  full;
  logic [DATA_WIDTH-1:0] wr_val;
  logic [DATA_WIDTH-1:0] rd_val;
  iidl_pkg::status_e     status_d;

  logic [iidl_pkg::VALUE_W-1:0]  removed_q;
  logic [iidl_pkg::STATUS_W-1:0] status_q;
  logic [iidl_pkg::COUNT_W-1:0]  count_out_q;

  assign pos_ext   = CMP_W'(position_i);
  assign cnt_ext   = CMP_W'(count_q);
  assign is_insert = (op_i == iidl_pkg::CMD_INSERT);
  assign full      = (count_q == CNT_W'(DEPTH));
  assign ins_ok    = is_insert && (pos_ext <= cnt_ext) && !full;
  assign del_ok    = !is_insert && (pos_ext < cnt_ext);
  assign wr_val    = DATA_WIDTH'(value_i);

  // read port for delete
  always_comb begin
    rd_val = '0;
    for (int i = 0; i < RD_N; i++) begin
      if (position_i == iidl_pkg::POS_W'(i)) rd_val = entries_q[i];
    end
  end

  always_comb begin
    if (is_insert) begin
      if (pos_ext > cnt_ext) status_d = iidl_pkg::ST_RANGE;
      else if (full)         status_d = iidl_pkg::ST_FULL;
      else                   status_d = iidl_pkg::ST_DONE;
    end else begin
      status_d = del_ok ? iidl_pkg::ST_DONE : iidl_pkg::ST_RANGE;
    end
  end

  // per-entry shift multiplexers
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      entries_d[i] = entries_q[i];
      if (ins_ok) begin
        if (CMP_W'(i) == pos_ext)                   entries_d[i] = wr_val;
        else if (i > 0 && CMP_W'(i) > pos_ext)      entries_d[i] = entries_q[(i > 0) ? i - 1 : 0];
      end else if (del_ok) begin
        if (i + 1 < DEPTH && CMP_W'(i) >= pos_ext)  entries_d[i] = entries_q[(i + 1 < DEPTH) ? i + 1 : i];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (ins_ok)      count_d = count_q + CNT_W'(1);
    else if (del_ok) count_d = count_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      for (int i = 0; i < DEPTH; i++) entries_q[i] <= entries_d[i];
      removed_q   <= del_ok ? iidl_pkg::VALUE_W'(rd_val) : '0;
      status_q    <= status_d;
      count_out_q <= iidl_pkg::COUNT_W'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  assign removed_value_o = removed_q;
  assign status_o        = status_q;
  assign count_o         = count_out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && ins_ok |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("insert did not grow the list");

  a_delete_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && del_ok |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("delete did not shrink the list");

  a_error_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && !ins_ok && !del_ok |=> $stable(count_q) && status_q != iidl_pkg::ST_DONE)
    else $error("rejected request changed the list");

endmodule

### design/indexed_insert_delete_list.sv
`timescale 1ns / 1ps

// ordered list of up to DEPTH values with insert and delete at a position
// request channel (req): cmd selects insert or delete, position picks the
//   list slot, value is stored on insert and ignored on delete
// response channel (rsp): one response per request with removed_value
//   (zero unless a delete succeeded), status (done, out of range, full)
//   and count, the number of entries after the operation
// latency: the response is valid the cycle after the request is taken
// throughput: one request per cycle if rsp is taken; all entries move at once
//   via their own multiplexers, so the op completes in the accepting cycle
// the response register parts the two channels: a new request is taken
//   while a response waits, as long as that response leaves in the same cycle
// a stalled receiver holds the response; req.ready drops until it is taken
// reset clears the entry count and the response valid; stored entries keep
//   whatever they hold and are only read below the count
module indexed_insert_delete_list #(
  parameter int unsigned DEPTH      = iidl_pkg::IIDL_DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = iidl_pkg::IIDL_DATA_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  iidl_req_if.sink    req,
  iidl_rsp_if.source  rsp
);

  iidl_pkg::ctl_cmd_t ctl_cmd;

  // handshake control and response valid
  iidl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .out_valid_o (rsp.valid),
    .out_ready_i (rsp.ready),
    .cmd_o       (ctl_cmd)
  );

  // entry storage, count and response registers
  iidl_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (ctl_cmd),
    .op_i            (req.cmd),
    .position_i      (req.position),
    .value_i         (req.value),
    .removed_value_o (rsp.removed_value),
    .status_o        (rsp.status),
    .count_o         (rsp.count)
  );

endmodule
